FILE: src/msl_pkg.sv
// Shared types, constants and helpers for the multi-shelf list splice engine.
`default_nettype none

package msl_pkg;

    // Sizing
    localparam int SHELVES = 16;
    localparam int BOOKS   = 64;
    localparam int BOOK_W  = 7;
    localparam int SHELF_W = 4;
    localparam int CMD_W   = 3;
    localparam int BOOK_AW  = (BOOKS > 1) ? $clog2(BOOKS) : 1;
    localparam int SHELF_AW = (SHELVES > 1) ? $clog2(SHELVES) : 1;

    // Config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [BOOK_W-1:0]  book_t;
    typedef logic [SHELF_W-1:0] shelf_t;
    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [APB_ADDR_W-3:0] reg_idx_t;

    // Register indexes
    localparam reg_idx_t REG_BOOK_COUNT = reg_idx_t'(0);

    // Command codes
    localparam cmd_t CMD_INIT     = 3'd0;
    localparam cmd_t CMD_MV_FB    = 3'd1;
    localparam cmd_t CMD_MV_BF    = 3'd2;
    localparam cmd_t CMD_SP_FRONT = 3'd3;
    localparam cmd_t CMD_SP_BACK  = 3'd4;
    localparam cmd_t CMD_DUMP     = 3'd5;

    localparam book_t BOOK_NONE      = '0;
    localparam book_t BOOK_ONE       = book_t'(1);
    localparam book_t BOOK_MAX       = book_t'(BOOKS);
    localparam book_t BOOK_COUNT_RST = book_t'(64);

    typedef struct packed {
        cmd_t   cmd;
        shelf_t src_shelf;
        shelf_t dest_shelf;
    } cmd_item_t;

    typedef struct packed {
        book_t book;
        book_t position;
        logic  shelf_empty;
        logic  last;
    } rsp_item_t;

    // One write into the head/tail table
    typedef struct packed {
        logic   head_en;
        logic   tail_en;
        shelf_t shelf;
        book_t  head;
        book_t  tail;
    } shelf_wr_t;

    // Link memory read and write requests
    typedef struct packed {
        logic  rd_en;
        book_t rd_book;
        logic  nx_we;
        book_t nx_book;
        book_t nx_data;
        logic  pv_we;
        book_t pv_book;
        book_t pv_data;
    } link_req_t;

    function automatic logic shelf_ok(shelf_t s);
        return (32'(s) < SHELVES);
    endfunction

    // Saturate the configured count to the number of books
    function automatic book_t book_clamp(book_t c);
        return (c > BOOK_MAX) ? BOOK_MAX : c;
    endfunction

endpackage

`default_nettype wire

FILE: src/msl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/msl_shelf_table.sv
// Per-shelf head and tail registers with one read address and two write ports.
`default_nettype none

module msl_shelf_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               init,
    input  msl_pkg::book_t     init_count,
    input  msl_pkg::shelf_t    rd_shelf,
    output msl_pkg::book_t     rd_head,
    output msl_pkg::book_t     rd_tail,
    input  msl_pkg::shelf_wr_t wr_a,
    input  msl_pkg::shelf_wr_t wr_b
);
    import msl_pkg::*;

    book_t head_reg [SHELVES];
    book_t tail_reg [SHELVES];

    logic [SHELF_AW-1:0] rd_idx;
    logic [SHELF_AW-1:0] wa_idx;
    logic [SHELF_AW-1:0] wb_idx;
    book_t               rst_count;

    assign rd_idx    = SHELF_AW'(rd_shelf);
    assign wa_idx    = SHELF_AW'(wr_a.shelf);
    assign wb_idx    = SHELF_AW'(wr_b.shelf);
    assign rst_count = book_clamp(BOOK_COUNT_RST);

    // Shelves out of range read as empty
    assign rd_head = shelf_ok(rd_shelf) ? head_reg[rd_idx] : BOOK_NONE;
    assign rd_tail = shelf_ok(rd_shelf) ? tail_reg[rd_idx] : BOOK_NONE;

    // Reset puts every book on shelf 0, init puts books 1..init_count there; port b wins over port a
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHELVES; i++)
            begin
                head_reg[i] <= (i == 0 && rst_count != BOOK_NONE) ? BOOK_ONE : BOOK_NONE;
                tail_reg[i] <= (i == 0) ? rst_count : BOOK_NONE;
            end
        end
        else if (init)
        begin
            for (int i = 0; i < SHELVES; i++)
            begin
                head_reg[i] <= (i == 0 && init_count != BOOK_NONE) ? BOOK_ONE : BOOK_NONE;
                tail_reg[i] <= (i == 0) ? init_count : BOOK_NONE;
            end
        end
        else
        begin
            if (wr_a.head_en && shelf_ok(wr_a.shelf))
            begin
                head_reg[wa_idx] <= wr_a.head;
            end
            if (wr_a.tail_en && shelf_ok(wr_a.shelf))
            begin
                tail_reg[wa_idx] <= wr_a.tail;
            end
            if (wr_b.head_en && shelf_ok(wr_b.shelf))
            begin
                head_reg[wb_idx] <= wr_b.head;
            end
            if (wr_b.tail_en && shelf_ok(wr_b.shelf))
            begin
                tail_reg[wb_idx] <= wr_b.tail;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/msl_link_store.sv
// Next and prev link memories with valid bits that stand in for the init pattern.
`default_nettype none

module msl_link_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  msl_pkg::book_t     count,
    input  msl_pkg::link_req_t req,
    output msl_pkg::book_t     nx_q,
    output msl_pkg::book_t     pv_q
);
    import msl_pkg::*;

    logic [BOOKS-1:0]   nx_valid_reg;
    logic [BOOKS-1:0]   pv_valid_reg;
    logic               nx_hit_reg;
    logic               pv_hit_reg;
    book_t              rd_book_reg;
    book_t              nx_ram_q;
    book_t              pv_ram_q;
    book_t              nx_init;
    book_t              pv_init;
    logic               nx_we_ok;
    logic               pv_we_ok;
    logic [BOOK_AW-1:0] rd_addr;
    logic [BOOK_AW-1:0] nx_addr;
    logic [BOOK_AW-1:0] pv_addr;

    // Book b lives at entry b-1
    function automatic logic [BOOK_AW-1:0] to_addr(book_t b);
        book_t d;
        d = b - BOOK_ONE;
        return d[BOOK_AW-1:0];
    endfunction

    assign rd_addr  = to_addr(req.rd_book);
    assign nx_addr  = to_addr(req.nx_book);
    assign pv_addr  = to_addr(req.pv_book);
    assign nx_we_ok = req.nx_we && (req.nx_book != BOOK_NONE);
    assign pv_we_ok = req.pv_we && (req.pv_book != BOOK_NONE);

    msl_ram #(
        .WIDTH (BOOK_W),
        .DEPTH (BOOKS)
    ) u_next_ram (
        .clk     (clk),
        .wr_en   (nx_we_ok),
        .wr_addr (nx_addr),
        .wr_data (req.nx_data),
        .rd_en   (req.rd_en),
        .rd_addr (rd_addr),
        .rd_data (nx_ram_q)
    );

    msl_ram #(
        .WIDTH (BOOK_W),
        .DEPTH (BOOKS)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (pv_we_ok),
        .wr_addr (pv_addr),
        .wr_data (req.pv_data),
        .rd_en   (req.rd_en),
        .rd_addr (rd_addr),
        .rd_data (pv_ram_q)
    );

    // Valid bits: cleared by reset or init, set by any write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_valid_reg <= '0;
            pv_valid_reg <= '0;
        end
        else if (clear)
        begin
            nx_valid_reg <= '0;
            pv_valid_reg <= '0;
        end
        else
        begin
            if (nx_we_ok)
            begin
                nx_valid_reg[nx_addr] <= 1'b1;
            end
            if (pv_we_ok)
            begin
                pv_valid_reg[pv_addr] <= 1'b1;
            end
        end
    end

    // Track which book was read and whether its entries were written
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_book_reg <= req.rd_book;
            nx_hit_reg  <= nx_valid_reg[rd_addr];
            pv_hit_reg  <= pv_valid_reg[rd_addr];
        end
    end

    // Init pattern: books 1..count form one chain
    assign nx_init = (rd_book_reg < count) ? (rd_book_reg + BOOK_ONE) : BOOK_NONE;
    assign pv_init = (rd_book_reg <= count) ? (rd_book_reg - BOOK_ONE) : BOOK_NONE;

    assign nx_q = nx_hit_reg ? nx_ram_q : nx_init;
    assign pv_q = pv_hit_reg ? pv_ram_q : pv_init;

endmodule

`default_nettype wire

FILE: src/multi_shelf_list_splice_engine.sv
// Top level: command sequencer, result register and config port of the shelf engine.
// Moves pass through unlink, clear and link states (link skipped onto an empty shelf); a splice
// uses its own state, init is done from idle, and a dump walks the shelf through the link memory.
// One item is in work at a time; a waiting result stalls a dump but does not hold off the next item after it.
// Reset: book_count is 64, shelf 0 holds books 1..64, all link valid bits clear at once.
`default_nettype none

module multi_shelf_list_splice_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  msl_pkg::cmd_item_t                cmd_item,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output msl_pkg::rsp_item_t                rsp_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [msl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import msl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_MV_UNLINK = 6'b000010,
        ST_MV_CLEAR  = 6'b000100,
        ST_MV_LINK   = 6'b001000,
        ST_SPLICE    = 6'b010000,
        ST_DUMP      = 6'b100000
    } state_t;

    state_t    state_reg, state_next;
    shelf_t    s_reg, s_next;
    shelf_t    d_reg, d_next;
    logic      fb_reg, fb_next;
    book_t     b_reg, b_next;
    book_t     t_reg, t_next;
    book_t     cur_reg, cur_next;
    book_t     pos_reg, pos_next;
    book_t     count_reg, count_next;
    book_t     book_count_reg, book_count_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg, rsp_item_next;

    logic      init_pulse;
    logic      can_load;
    logic      rsp_load;
    logic      shelves_ok;
    logic      last_flag;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;
    book_t     bsel;
    book_t     clamped_count;
    shelf_t    rd_shelf;
    book_t     rd_head;
    book_t     rd_tail;
    book_t     nx_q;
    book_t     pv_q;
    shelf_wr_t wr_a;
    shelf_wr_t wr_b;
    link_req_t link_req;

    assign clamped_count = book_clamp(book_count_reg);

    msl_shelf_table u_shelf_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (init_pulse),
        .init_count (clamped_count),
        .rd_shelf   (rd_shelf),
        .rd_head    (rd_head),
        .rd_tail    (rd_tail),
        .wr_a       (wr_a),
        .wr_b       (wr_b)
    );

    msl_link_store u_link_store (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (init_pulse),
        .count (count_reg),
        .req   (link_req),
        .nx_q  (nx_q),
        .pv_q  (pv_q)
    );

    // Config port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == REG_BOOK_COUNT) ? APB_DATA_W'(book_count_reg) : '0;

    always_comb
    begin
        book_count_next = book_count_reg;
        if (cfg_wr && cfg_idx == REG_BOOK_COUNT)
        begin
            book_count_next = pwdata[BOOK_W-1:0];
        end
    end

    // Handshake
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign can_load  = !rsp_valid_reg || !rsp_stall;

    assign shelves_ok = shelf_ok(cmd_item.src_shelf) && shelf_ok(cmd_item.dest_shelf);

    // Shelf table read address: source while idle, unlinking and dumping, else destination
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:                             rd_shelf = cmd_item.src_shelf;
            ST_MV_CLEAR, ST_MV_LINK, ST_SPLICE:  rd_shelf = d_reg;
            default:                             rd_shelf = s_reg;
        endcase
    end

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        s_next        = s_reg;
        d_next        = d_reg;
        fb_next       = fb_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        init_pulse    = 1'b0;
        rsp_load      = 1'b0;
        rsp_item_next = rsp_item_reg;
        wr_a          = '0;
        wr_b          = '0;
        link_req      = '0;
        bsel          = BOOK_NONE;
        last_flag     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    s_next = cmd_item.src_shelf;
                    d_next = cmd_item.dest_shelf;
                    unique case (cmd_item.cmd) inside
                        CMD_INIT:
                        begin
                            init_pulse = 1'b1;
                            count_next = clamped_count;
                        end
                        CMD_MV_FB, CMD_MV_BF:
                        begin
                            fb_next = (cmd_item.cmd == CMD_MV_FB);
                            bsel    = (cmd_item.cmd == CMD_MV_FB) ? rd_head : rd_tail;
                            if (shelves_ok && bsel != BOOK_NONE)
                            begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_book = bsel;
                                b_next           = bsel;
                                state_next       = ST_MV_UNLINK;
                            end
                        end
                        CMD_SP_FRONT, CMD_SP_BACK:
                        begin
                            fb_next = (cmd_item.cmd == CMD_SP_FRONT);
                            if (shelves_ok && cmd_item.src_shelf != cmd_item.dest_shelf
                                && rd_head != BOOK_NONE)
                            begin
                                b_next     = rd_head;
                                t_next     = rd_tail;
                                state_next = ST_SPLICE;
                            end
                        end
                        CMD_DUMP:
                        begin
                            cur_next   = rd_head;
                            pos_next   = BOOK_ONE;
                            state_next = ST_DUMP;
                            if (rd_head != BOOK_NONE)
                            begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_book = rd_head;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Take the book out: bridge its neighbors or fix the source ends
            ST_MV_UNLINK:
            begin
                wr_a.shelf = s_reg;
                if (pv_q != BOOK_NONE)
                begin
                    link_req.nx_we   = 1'b1;
                    link_req.nx_book = pv_q;
                    link_req.nx_data = nx_q;
                end
                else
                begin
                    wr_a.head_en = 1'b1;
                    wr_a.head    = nx_q;
                end
                if (nx_q != BOOK_NONE)
                begin
                    link_req.pv_we   = 1'b1;
                    link_req.pv_book = nx_q;
                    link_req.pv_data = pv_q;
                end
                else
                begin
                    wr_a.tail_en = 1'b1;
                    wr_a.tail    = pv_q;
                end
                state_next = ST_MV_CLEAR;
            end

            // Rewrite the moved book's own links against the destination
            ST_MV_CLEAR:
            begin
                link_req.nx_we   = 1'b1;
                link_req.nx_book = b_reg;
                link_req.pv_we   = 1'b1;
                link_req.pv_book = b_reg;
                if (rd_head == BOOK_NONE)
                begin
                    wr_b.head_en = 1'b1;
                    wr_b.tail_en = 1'b1;
                    wr_b.shelf   = d_reg;
                    wr_b.head    = b_reg;
                    wr_b.tail    = b_reg;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    link_req.nx_data = fb_reg ? BOOK_NONE : rd_head;
                    link_req.pv_data = fb_reg ? rd_tail : BOOK_NONE;
                    state_next       = ST_MV_LINK;
                end
            end

            // Point the destination end at the moved book
            ST_MV_LINK:
            begin
                wr_b.shelf = d_reg;
                if (fb_reg)
                begin
                    link_req.nx_we   = 1'b1;
                    link_req.nx_book = rd_tail;
                    link_req.nx_data = b_reg;
                    wr_b.tail_en     = 1'b1;
                    wr_b.tail        = b_reg;
                end
                else
                begin
                    link_req.pv_we   = 1'b1;
                    link_req.pv_book = rd_head;
                    link_req.pv_data = b_reg;
                    wr_b.head_en     = 1'b1;
                    wr_b.head        = b_reg;
                end
                state_next = ST_IDLE;
            end

            // Join the whole source chain onto the destination
            ST_SPLICE:
            begin
                wr_a.head_en = 1'b1;
                wr_a.tail_en = 1'b1;
                wr_a.shelf   = s_reg;
                wr_b.shelf   = d_reg;
                if (rd_head == BOOK_NONE)
                begin
                    wr_b.head_en = 1'b1;
                    wr_b.tail_en = 1'b1;
                    wr_b.head    = b_reg;
                    wr_b.tail    = t_reg;
                end
                else if (fb_reg)
                begin
                    link_req.nx_we   = 1'b1;
                    link_req.nx_book = t_reg;
                    link_req.nx_data = rd_head;
                    link_req.pv_we   = 1'b1;
                    link_req.pv_book = rd_head;
                    link_req.pv_data = t_reg;
                    wr_b.head_en     = 1'b1;
                    wr_b.head        = b_reg;
                end
                else
                begin
                    link_req.nx_we   = 1'b1;
                    link_req.nx_book = rd_tail;
                    link_req.nx_data = b_reg;
                    link_req.pv_we   = 1'b1;
                    link_req.pv_book = b_reg;
                    link_req.pv_data = rd_tail;
                    wr_b.tail_en     = 1'b1;
                    wr_b.tail        = t_reg;
                end
                state_next = ST_IDLE;
            end

            // Walk the shelf, one book per free output slot
            ST_DUMP:
            begin
                if (can_load)
                begin
                    rsp_load = 1'b1;
                    if (cur_reg == BOOK_NONE)
                    begin
                        rsp_item_next = '{book: BOOK_NONE, position: BOOK_NONE,
                                          shelf_empty: 1'b1, last: 1'b1};
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        last_flag     = (nx_q == BOOK_NONE) || (pos_reg == BOOK_MAX);
                        rsp_item_next = '{book: cur_reg, position: pos_reg,
                                          shelf_empty: 1'b0, last: last_flag};
                        if (last_flag)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            link_req.rd_en   = 1'b1;
                            link_req.rd_book = nx_q;
                            cur_next         = nx_q;
                            pos_next         = pos_reg + BOOK_ONE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            book_count_reg <= BOOK_COUNT_RST;
            count_reg      <= book_clamp(BOOK_COUNT_RST);
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            book_count_reg <= book_count_next;
            count_reg      <= count_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        d_reg        <= d_next;
        fb_reg       <= fb_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        rsp_item_reg <= rsp_item_next;
    end

    // The walk position stays within one shelf's worth of books
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (pos_reg != BOOK_NONE && pos_reg <= BOOK_MAX))
        else $error("dump position out of range");

    // A final result ends the dump
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_item_next.last) |=> (state_reg == ST_IDLE))
        else $error("dump continued past last result");

    // Link writes never target the null book
    a_link_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (link_req.nx_we || link_req.pv_we) |->
        ((!link_req.nx_we || link_req.nx_book != BOOK_NONE) &&
         (!link_req.pv_we || link_req.pv_book != BOOK_NONE)))
        else $error("link write to null book");

    // Results come only out of a dump
    a_rsp_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DUMP))
        else $error("result outside a dump");

endmodule

`default_nettype wire
